// File: rtl/alarm_change_detector_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the alarm change detector
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ALARM_CHANGE_DETECTOR_CORE_MACROS_SVH
`define ALARM_CHANGE_DETECTOR_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that a condition holds at every edge
`define ACD_ASSERT_ALWAYS(name, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("acd: invariant violated");

// Check that a condition implies another in the same cycle
`define ACD_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("acd: implication violated");

// Check that a condition implies another in the next cycle
`define ACD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("acd: next-cycle implication violated");

`else

`define ACD_ASSERT_ALWAYS(name, expr)
`define ACD_ASSERT_IMPLY(name, ante, cons)
`define ACD_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// File: rtl/acd_pkg.sv
// ----------------------------------------------------------------------------
// acd_pkg
// Shared constants and types of the alarm change detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package acd_pkg;

  // Default table dimensions
  localparam int ACD_MAX_DEVICES = 16;
  localparam int ACD_MAX_ALARMS  = 64;

  // Record kinds of a result word
  typedef enum logic [1:0] {
    KIND_FIRST = 2'd0,
    KIND_OLD   = 2'd1,
    KIND_NEW   = 2'd2,
    KIND_DROP  = 2'd3
  } acd_kind_t;

  // One result word
  typedef struct packed {
    acd_kind_t   kind;
    logic [31:0] event_time;
    logic [31:0] prev_time;
    logic [31:0] device_key;
    logic [31:0] alarm_key;
    logic [31:0] value;
    logic        last;
  } acd_rec_t;

endpackage

// File: rtl/acd_outbuf.sv
// ----------------------------------------------------------------------------
// acd_outbuf
// Output register: holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acd_outbuf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  acd_pkg::acd_rec_t push_rec,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_record_kind,
  output logic [31:0]      out_event_time_res,
  output logic [31:0]      out_previous_time,
  output logic [31:0]      out_device_key_res,
  output logic [31:0]      out_alarm_key_res,
  output logic [31:0]      out_reported_value,
  output logic             out_last_of_run
);
  import acd_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  acd_rec_t rec_r;

  // Take a new word when empty or when the held word leaves this cycle
  assign push_ready = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (push_valid && push_ready) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    if (push_valid && push_ready) begin
      rec_r <= push_rec;
    end
  end

  assign out_valid          = valid_r;
  assign out_record_kind    = rec_r.kind;
  assign out_event_time_res = rec_r.event_time;
  assign out_previous_time  = rec_r.prev_time;
  assign out_device_key_res = rec_r.device_key;
  assign out_alarm_key_res  = rec_r.alarm_key;
  assign out_reported_value = rec_r.value;
  assign out_last_of_run    = rec_r.last;

endmodule

// File: rtl/acd_seq.sv
// ----------------------------------------------------------------------------
// acd_seq
// Search sequencer with the device memory and the alarm slot memory.
// Scans devices, then the slots of the matching device, and writes back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "alarm_change_detector_core_macros.svh"

module acd_seq #(
  parameter int MAX_DEVICES           = acd_pkg::ACD_MAX_DEVICES,
  parameter int MAX_ALARMS_PER_DEVICE = acd_pkg::ACD_MAX_ALARMS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       in_event_time,
  input  logic [31:0]       in_device_key,
  input  logic [31:0]       in_alarm_key,
  input  logic [31:0]       in_new_value,
  output logic              push_valid,
  input  logic              push_ready,
  output acd_pkg::acd_rec_t push_rec
);
  import acd_pkg::*;

  localparam int DEV_IDX_W  = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int DEV_CNT_W  = $clog2(MAX_DEVICES + 1);
  localparam int ALM_IDX_W  = (MAX_ALARMS_PER_DEVICE > 1) ? $clog2(MAX_ALARMS_PER_DEVICE) : 1;
  localparam int ALM_CNT_W  = $clog2(MAX_ALARMS_PER_DEVICE + 1);
  localparam int SLOT_TOTAL = MAX_DEVICES * MAX_ALARMS_PER_DEVICE;
  localparam int SLOT_AW    = (SLOT_TOTAL > 1) ? $clog2(SLOT_TOTAL) : 1;

  typedef struct packed {
    logic [31:0]          key;
    logic [ALM_CNT_W-1:0] cnt;
  } dev_entry_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] value;
    logic [31:0] stamp;
  } slot_entry_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DSCAN  = 6'b000010,
    S_ASTART = 6'b000100,
    S_ASCAN  = 6'b001000,
    S_OLD    = 6'b010000,
    S_NEW    = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  logic [DEV_CNT_W-1:0] dev_count_r, dev_count_nxt;
  logic [DEV_IDX_W-1:0] didx_r, didx_nxt;
  logic [DEV_IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [ALM_IDX_W-1:0] aidx_r, aidx_nxt;
  logic [ALM_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SLOT_AW-1:0]   base_r, base_nxt;
  logic [31:0]          old_time_r, old_time_nxt;
  logic [31:0]          old_val_r, old_val_nxt;
  acd_kind_t            kind_r, kind_nxt;

  // Latched input word
  logic [31:0] ev_time_r;
  logic [31:0] dev_key_r;
  logic [31:0] alm_key_r;
  logic [31:0] val_r;

  // Memory ports
  dev_entry_t           dev_mem [MAX_DEVICES];
  dev_entry_t           dev_rd_r;
  logic [DEV_IDX_W-1:0] dev_raddr;
  logic                 dev_we;
  logic [DEV_IDX_W-1:0] dev_waddr;
  dev_entry_t           dev_wdata;

  slot_entry_t          slot_mem [SLOT_TOTAL];
  slot_entry_t          slot_rd_r;
  logic [SLOT_AW-1:0]   slot_raddr;
  logic                 slot_we;
  logic [SLOT_AW-1:0]   slot_waddr;
  slot_entry_t          slot_wdata;

  logic in_fire;
  logic dev_hit, dev_last, dev_full, dev_cnt_inc;
  logic alm_hit, alm_last, alm_full;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Compare the entry read last cycle against the latched keys
  assign dev_hit  = (dev_count_r != '0) && (dev_rd_r.key == dev_key_r);
  assign dev_last = (dev_count_r == '0) ||
                    ((DEV_CNT_W'(didx_r) + DEV_CNT_W'(1)) == dev_count_r);
  assign dev_full = (dev_count_r == DEV_CNT_W'(MAX_DEVICES));
  assign alm_hit  = (cnt_r != '0) && (slot_rd_r.key == alm_key_r);
  assign alm_last = (cnt_r == '0) ||
                    ((ALM_CNT_W'(aidx_r) + ALM_CNT_W'(1)) == cnt_r);
  assign alm_full = (cnt_r == ALM_CNT_W'(MAX_ALARMS_PER_DEVICE));

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    dev_count_nxt = dev_count_r;
    didx_nxt      = didx_r;
    hit_idx_nxt   = hit_idx_r;
    aidx_nxt      = aidx_r;
    cnt_nxt       = cnt_r;
    base_nxt      = base_r;
    old_time_nxt  = old_time_r;
    old_val_nxt   = old_val_r;
    kind_nxt      = kind_r;
    dev_raddr     = '0;
    dev_we        = 1'b0;
    dev_waddr     = hit_idx_r;
    dev_wdata     = '{key: dev_key_r, cnt: ALM_CNT_W'(cnt_r + ALM_CNT_W'(1))};
    slot_raddr    = base_r;
    slot_we       = 1'b0;
    slot_waddr    = base_r;
    slot_wdata    = '{key: alm_key_r, value: val_r, stamp: ev_time_r};
    dev_cnt_inc   = 1'b0;
    push_valid    = 1'b0;
    push_rec      = '{kind: kind_r, event_time: ev_time_r, prev_time: 32'd0,
                      device_key: dev_key_r, alarm_key: alm_key_r,
                      value: val_r, last: 1'b1};

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          didx_nxt  = '0;
          state_nxt = S_DSCAN;
        end
      end

      S_DSCAN: begin
        // Issue the next device read speculatively
        dev_raddr = dev_last ? '0 : DEV_IDX_W'(didx_r + DEV_IDX_W'(1));
        priority if (dev_hit) begin
          hit_idx_nxt = didx_r;
          cnt_nxt     = dev_rd_r.cnt;
          base_nxt    = SLOT_AW'(int'(didx_r) * MAX_ALARMS_PER_DEVICE);
          state_nxt   = S_ASTART;
        end else if (dev_last) begin
          if (dev_full) begin
            kind_nxt = KIND_DROP;
          end else begin
            // Store the new device and its first alarm
            dev_we        = 1'b1;
            dev_waddr     = DEV_IDX_W'(dev_count_r);
            dev_wdata     = '{key: dev_key_r, cnt: ALM_CNT_W'(1)};
            slot_we       = 1'b1;
            slot_waddr    = SLOT_AW'(int'(dev_count_r) * MAX_ALARMS_PER_DEVICE);
            dev_cnt_inc   = 1'b1;
            dev_count_nxt = DEV_CNT_W'(dev_count_r + DEV_CNT_W'(1));
            kind_nxt      = KIND_FIRST;
          end
          state_nxt = S_NEW;
        end else begin
          didx_nxt = DEV_IDX_W'(didx_r + DEV_IDX_W'(1));
        end
      end

      S_ASTART: begin
        slot_raddr = base_r;
        aidx_nxt   = '0;
        state_nxt  = S_ASCAN;
      end

      S_ASCAN: begin
        slot_raddr = alm_last ? base_r :
                     SLOT_AW'(base_r + SLOT_AW'(aidx_r) + SLOT_AW'(1));
        priority if (alm_hit) begin
          if (slot_rd_r.value == val_r) begin
            // Unchanged value: drop silently
            state_nxt = S_IDLE;
          end else begin
            old_time_nxt = slot_rd_r.stamp;
            old_val_nxt  = slot_rd_r.value;
            slot_we      = 1'b1;
            slot_waddr   = SLOT_AW'(base_r + SLOT_AW'(aidx_r));
            kind_nxt     = KIND_NEW;
            state_nxt    = S_OLD;
          end
        end else if (alm_last) begin
          if (alm_full) begin
            kind_nxt = KIND_DROP;
          end else begin
            // Append a slot and bump the device's alarm count
            slot_we    = 1'b1;
            slot_waddr = SLOT_AW'(base_r + SLOT_AW'(cnt_r));
            dev_we     = 1'b1;
            kind_nxt   = KIND_FIRST;
          end
          state_nxt = S_NEW;
        end else begin
          aidx_nxt = ALM_IDX_W'(aidx_r + ALM_IDX_W'(1));
        end
      end

      S_OLD: begin
        push_valid         = 1'b1;
        push_rec.kind      = KIND_OLD;
        push_rec.prev_time = old_time_r;
        push_rec.value     = old_val_r;
        push_rec.last      = 1'b0;
        if (push_ready) begin
          state_nxt = S_NEW;
        end
      end

      S_NEW: begin
        push_valid = 1'b1;
        if (push_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dev_count_r <= '0;
    end else begin
      state_r     <= state_nxt;
      dev_count_r <= dev_count_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    didx_r     <= didx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    aidx_r     <= aidx_nxt;
    cnt_r      <= cnt_nxt;
    base_r     <= base_nxt;
    old_time_r <= old_time_nxt;
    old_val_r  <= old_val_nxt;
    kind_r     <= kind_nxt;
  end

  // Capture the input word
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ev_time_r <= in_event_time;
      dev_key_r <= in_device_key;
      alm_key_r <= in_alarm_key;
      val_r     <= in_new_value;
    end
  end

  // Device memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (dev_we) begin
      dev_mem[dev_waddr] <= dev_wdata;
    end
    dev_rd_r <= dev_mem[dev_raddr];
  end

  // Slot memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_rd_r <= slot_mem[slot_raddr];
  end

  `ACD_ASSERT_ALWAYS(a_dev_count_bound, dev_count_r <= DEV_CNT_W'(MAX_DEVICES))
  `ACD_ASSERT_NEXT(a_dev_count_hold, !dev_cnt_inc, $stable(dev_count_r))
  `ACD_ASSERT_IMPLY(a_dev_write_state, dev_we, (state_r == S_DSCAN) || (state_r == S_ASCAN))
  `ACD_ASSERT_NEXT(a_old_then_new, push_valid && push_ready && (state_r == S_OLD), state_r == S_NEW)
  `ACD_ASSERT_IMPLY(a_open_is_old, push_valid && !push_rec.last, push_rec.kind == KIND_OLD)

endmodule

// File: rtl/alarm_change_detector_core.sv
// ----------------------------------------------------------------------------
// alarm_change_detector_core
// Report-by-exception filter for alarm events.
// ----------------------------------------------------------------------------
// Input channel (in_*): one word per alarm event with time, device key,
// alarm key and value. Output channel (out_*): result words. A new device
// or alarm gives one first-report word; a changed value gives an old-value
// word followed by a new-value word; a full device or alarm table gives one
// drop word; an unchanged value gives none. out_last_of_run marks the final
// word of an event.
// One event is handled at a time. The sequencer scans the device entries,
// then the alarm slots of the matching device, one entry per cycle through
// the read port of each memory. The next event is accepted in the cycle
// after the last word of an event is loaded into the output register.
// Reset clears the device count and the control state only; no memory pass
// is needed, so events are accepted right after reset.
// A stalled receiver holds the output register; the sequencer waits only
// when it has a word to hand over and the register is still full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alarm_change_detector_core #(
  parameter int MAX_DEVICES           = acd_pkg::ACD_MAX_DEVICES,
  parameter int MAX_ALARMS_PER_DEVICE = acd_pkg::ACD_MAX_ALARMS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_event_time,
  input  logic [31:0] in_device_key,
  input  logic [31:0] in_alarm_key,
  input  logic [31:0] in_new_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_record_kind,
  output logic [31:0] out_event_time_res,
  output logic [31:0] out_previous_time,
  output logic [31:0] out_device_key_res,
  output logic [31:0] out_alarm_key_res,
  output logic [31:0] out_reported_value,
  output logic        out_last_of_run
);
  import acd_pkg::*;

  logic     push_valid;
  logic     push_ready;
  acd_rec_t push_rec;

  // Search and update
  acd_seq #(
    .MAX_DEVICES           (MAX_DEVICES),
    .MAX_ALARMS_PER_DEVICE (MAX_ALARMS_PER_DEVICE)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_event_time (in_event_time),
    .in_device_key (in_device_key),
    .in_alarm_key  (in_alarm_key),
    .in_new_value  (in_new_value),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_rec      (push_rec)
  );

  // Result register
  acd_outbuf u_outbuf (
    .clk                (clk),
    .rst_n              (rst_n),
    .push_valid         (push_valid),
    .push_ready         (push_ready),
    .push_rec           (push_rec),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_record_kind    (out_record_kind),
    .out_event_time_res (out_event_time_res),
    .out_previous_time  (out_previous_time),
    .out_device_key_res (out_device_key_res),
    .out_alarm_key_res  (out_alarm_key_res),
    .out_reported_value (out_reported_value),
    .out_last_of_run    (out_last_of_run)
  );

endmodule

// File: sim/alarm_change_detector_checker.sv
// ----------------------------------------------------------------------------
// Alarm change detector checker
// Watches both channels of the detector. Keeps its own copy of the device
// table and alarm slots, turns every accepted event word into the result
// words it should produce, and matches the result words in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alarm_change_detector_checker #(
  parameter int MAX_DEVICES           = acd_pkg::ACD_MAX_DEVICES,
  parameter int MAX_ALARMS_PER_DEVICE = acd_pkg::ACD_MAX_ALARMS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] in_event_time,
  input  logic [31:0] in_device_key,
  input  logic [31:0] in_alarm_key,
  input  logic [31:0] in_new_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_record_kind,
  input  logic [31:0] out_event_time_res,
  input  logic [31:0] out_previous_time,
  input  logic [31:0] out_device_key_res,
  input  logic [31:0] out_alarm_key_res,
  input  logic [31:0] out_reported_value,
  input  logic        out_last_of_run,
  output int          fail_count,
  output int          pending
);
  import acd_pkg::*;

  localparam int SLOT_COUNT = MAX_DEVICES * MAX_ALARMS_PER_DEVICE;

  // Shadow of the device table and alarm slots
  logic [31:0] known_devices [MAX_DEVICES];
  int          device_total;
  int          slots_used [MAX_DEVICES];
  logic [31:0] slot_key   [SLOT_COUNT];
  logic [31:0] slot_value [SLOT_COUNT];
  logic [31:0] slot_stamp [SLOT_COUNT];

  acd_rec_t expected_words [$];

  function automatic void queue_word(acd_kind_t kind, logic [31:0] stamp,
                                     logic [31:0] old_stamp, logic [31:0] dev,
                                     logic [31:0] alarm, logic [31:0] value,
                                     logic last);
    acd_rec_t w;
    w.kind       = kind;
    w.event_time = stamp;
    w.prev_time  = old_stamp;
    w.device_key = dev;
    w.alarm_key  = alarm;
    w.value      = value;
    w.last       = last;
    expected_words.push_back(w);
  endfunction

  // Update the shadow table for one event and queue the words it produces
  function automatic void predict_event(logic [31:0] stamp, logic [31:0] dev,
                                        logic [31:0] alarm, logic [31:0] value);
    int dev_idx;
    int slot_idx;
    int base;
    dev_idx = -1;
    for (int i = 0; i < device_total; i++) begin
      if (dev_idx < 0 && known_devices[i] == dev) dev_idx = i;
    end

    // Unseen device: claim a table entry or drop
    if (dev_idx < 0) begin
      if (device_total >= MAX_DEVICES) begin
        queue_word(KIND_DROP, stamp, '0, dev, alarm, value, 1'b1);
      end else begin
        base = device_total * MAX_ALARMS_PER_DEVICE;
        known_devices[device_total] = dev;
        slots_used[device_total]    = 1;
        slot_key[base]              = alarm;
        slot_value[base]            = value;
        slot_stamp[base]            = stamp;
        device_total++;
        queue_word(KIND_FIRST, stamp, '0, dev, alarm, value, 1'b1);
      end
      return;
    end

    base     = dev_idx * MAX_ALARMS_PER_DEVICE;
    slot_idx = -1;
    for (int a = 0; a < slots_used[dev_idx]; a++) begin
      if (slot_idx < 0 && slot_key[base + a] == alarm) slot_idx = base + a;
    end

    // Known alarm: silent when unchanged, old and new words when changed
    if (slot_idx >= 0) begin
      if (slot_value[slot_idx] == value) return;
      queue_word(KIND_OLD, stamp, slot_stamp[slot_idx], dev, alarm,
                 slot_value[slot_idx], 1'b0);
      queue_word(KIND_NEW, stamp, '0, dev, alarm, value, 1'b1);
      slot_value[slot_idx] = value;
      slot_stamp[slot_idx] = stamp;
      return;
    end

    // Unseen alarm: append a slot or drop when the device is full
    if (slots_used[dev_idx] >= MAX_ALARMS_PER_DEVICE) begin
      queue_word(KIND_DROP, stamp, '0, dev, alarm, value, 1'b1);
    end else begin
      slot_idx             = base + slots_used[dev_idx];
      slot_key[slot_idx]   = alarm;
      slot_value[slot_idx] = value;
      slot_stamp[slot_idx] = stamp;
      slots_used[dev_idx]++;
      queue_word(KIND_FIRST, stamp, '0, dev, alarm, value, 1'b1);
    end
  endfunction

  function automatic int field_differs(string name, logic [31:0] want,
                                       logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Match result words first, then predict from the event word
  always @(posedge clk) begin
    acd_rec_t want;
    int       bad;
    if (!rst_n) begin
      device_total = 0;
      expected_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: kind %0d device %0h alarm %0h",
                 out_record_kind, out_device_key_res, out_alarm_key_res);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          bad  = 0;
          bad += field_differs("record_kind", 32'(want.kind), 32'(out_record_kind));
          bad += field_differs("event_time_res", want.event_time, out_event_time_res);
          bad += field_differs("previous_time", want.prev_time, out_previous_time);
          bad += field_differs("device_key_res", want.device_key, out_device_key_res);
          bad += field_differs("alarm_key_res", want.alarm_key, out_alarm_key_res);
          bad += field_differs("reported_value", want.value, out_reported_value);
          bad += field_differs("last_of_run", 32'(want.last), 32'(out_last_of_run));
          fail_count += bad;
        end
      end
      if (in_valid && in_ready) begin
        predict_event(in_event_time, in_device_key, in_alarm_key, in_new_value);
      end
    end
    pending = expected_words.size();
  end

endmodule

// File: sim/alarm_change_detector_core_tb.sv
// ----------------------------------------------------------------------------
// Alarm change detector testbench
// Drives directed events through every table case (new device, new alarm,
// changed and unchanged value, full device table), then a long random mix biased
// toward known devices and alarms. A checker beside the block predicts and
// matches every result word; this module feeds events and gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alarm_change_detector_core_tb;
  import acd_pkg::*;

  localparam int RANDOM_EVENTS   = 1500;
  localparam int POOL_ALARMS     = 6;
  localparam int DRAIN_INTERVAL  = 400;
  localparam int SETTLE_CYCLES   = ACD_MAX_DEVICES + ACD_MAX_ALARMS + 40;
  localparam int CYCLE_LIMIT     = 2_000_000;

  // Receiver ready patterns
  typedef enum logic [1:0] {
    RX_FREE,
    RX_HALF,
    RX_SPARSE,
    RX_MOSTLY
  } rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_event_time = '0;
  logic [31:0] in_device_key = '0;
  logic [31:0] in_alarm_key = '0;
  logic [31:0] in_new_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_record_kind;
  logic [31:0] out_event_time_res;
  logic [31:0] out_previous_time;
  logic [31:0] out_device_key_res;
  logic [31:0] out_alarm_key_res;
  logic [31:0] out_reported_value;
  logic        out_last_of_run;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int burst_left = 0;
  int rx_hold = 0;
  rx_mode_t rx_mode = RX_FREE;

  logic [31:0] dev_pool   [ACD_MAX_DEVICES];
  logic [31:0] alarm_pool [ACD_MAX_DEVICES][POOL_ALARMS];
  logic [31:0] last_dev, last_alarm, last_value;

  always #5 clk = ~clk;

  alarm_change_detector_core u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_event_time      (in_event_time),
    .in_device_key      (in_device_key),
    .in_alarm_key       (in_alarm_key),
    .in_new_value       (in_new_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_record_kind    (out_record_kind),
    .out_event_time_res (out_event_time_res),
    .out_previous_time  (out_previous_time),
    .out_device_key_res (out_device_key_res),
    .out_alarm_key_res  (out_alarm_key_res),
    .out_reported_value (out_reported_value),
    .out_last_of_run    (out_last_of_run)
  );

  alarm_change_detector_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_event_time      (in_event_time),
    .in_device_key      (in_device_key),
    .in_alarm_key       (in_alarm_key),
    .in_new_value       (in_new_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_record_kind    (out_record_kind),
    .out_event_time_res (out_event_time_res),
    .out_previous_time  (out_previous_time),
    .out_device_key_res (out_device_key_res),
    .out_alarm_key_res  (out_alarm_key_res),
    .out_reported_value (out_reported_value),
    .out_last_of_run    (out_last_of_run),
    .fail_count         (fail_count),
    .pending            (pending)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: drive out_ready from a randomly switched ready pattern
  always @(posedge clk) begin
    if (rx_hold == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_hold <= $urandom_range(20, 200);
    end else begin
      rx_hold <= rx_hold - 1;
    end
    case (rx_mode)
      RX_FREE:   out_ready <= 1'b1;
      RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 9) == 0);
      default:   out_ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Present one event word, in bursts with random gaps, and hold until taken
  task automatic send_event(input logic [31:0] stamp, input logic [31:0] dev,
                            input logic [31:0] alarm, input logic [31:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_event_time <= stamp;
    in_device_key <= dev;
    in_alarm_key  <= alarm;
    in_new_value  <= value;
    last_dev   = dev;
    last_alarm = alarm;
    last_value = value;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold off the sender until every expected word has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin
    int          pick;
    int          di;
    logic [31:0] value;

    for (int d = 0; d < ACD_MAX_DEVICES; d++) begin
      dev_pool[d] = $urandom;
      for (int a = 0; a < POOL_ALARMS; a++) alarm_pool[d][a] = $urandom;
    end
    dev_pool[0]      = 32'h0000_0000;
    dev_pool[1]      = 32'hFFFF_FFFF;
    alarm_pool[0][0] = 32'h0000_0000;
    alarm_pool[0][1] = 32'hFFFF_FFFF;
    alarm_pool[1][0] = 32'h0000_0000;
    alarm_pool[1][1] = 32'hAAAA_AAAA;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // New device, unchanged value, change at the extremes, new alarm
    send_event(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_event(32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_event(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    send_event(32'h0000_0005, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
    send_event(32'h0000_0006, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_event(32'h5555_5555, 32'hFFFF_FFFF, 32'h0000_0000, 32'h5555_5555);
    send_event(32'hAAAA_AAAA, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'hAAAA_AAAA);

    // Fill the device table, then overflow it
    for (int d = 2; d < ACD_MAX_DEVICES; d++) begin
      send_event($urandom, dev_pool[d], alarm_pool[d][0], $urandom);
    end
    send_event($urandom, 32'h1234_5678, $urandom, $urandom);
    send_event($urandom, dev_pool[3], $urandom, $urandom);
    wait_drained();

    // Random mix; fresh alarms lean on device 0 so its slots run out
    for (int n = 0; n < RANDOM_EVENTS; n++) begin
      pick = $urandom_range(0, 99);
      di   = $urandom_range(0, ACD_MAX_DEVICES - 1);
      if (pick < 60) begin
        value = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2);
        send_event($urandom, dev_pool[di],
                   alarm_pool[di][$urandom_range(0, POOL_ALARMS - 1)], value);
      end else if (pick < 80) begin
        if ($urandom_range(0, 1) == 0) di = 0;
        send_event($urandom, dev_pool[di], $urandom, $urandom);
      end else if (pick < 90) begin
        send_event($urandom, $urandom, $urandom, $urandom);
      end else begin
        send_event($urandom, last_dev, last_alarm, last_value);
      end
      if (n % DRAIN_INTERVAL == DRAIN_INTERVAL - 1) wait_drained();
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
